// ----- hdl/usan_pkg.sv -----
// Shared types, constants and byte-expansion functions for the UTF-8 byte sanitizer.
`default_nettype none

package usan_pkg;

  localparam logic [7:0] BYTE_TAB     = 8'd9;
  localparam logic [7:0] BYTE_LF      = 8'd10;
  localparam logic [7:0] BYTE_CR      = 8'd13;
  localparam logic [7:0] BYTE_SPACE   = 8'd32;
  localparam logic [7:0] BYTE_DEL     = 8'd127;
  localparam logic [7:0] BYTE_EURO    = 8'd128;
  localparam logic [7:0] BYTE_NEL     = 8'd133;
  localparam logic [7:0] BYTE_NBSP    = 8'd160;
  localparam logic [7:0] BYTE_LEAD2LO = 8'd194;
  localparam logic [7:0] BYTE_LEAD3LO = 8'd224;
  localparam logic [7:0] BYTE_LEAD4LO = 8'd240;
  localparam logic [7:0] BYTE_BADLO   = 8'd245;
  localparam logic [7:0] BYTE_C2      = 8'd194;
  localparam logic [7:0] BYTE_C3      = 8'd195;
  localparam logic [7:0] EURO_B0      = 8'd226;
  localparam logic [7:0] EURO_B1      = 8'd130;
  localparam logic [7:0] EURO_B2      = 8'd172;
  localparam logic [7:0] LATIN_OFFSET = 8'd64;

  typedef enum logic {
    TOK_SOLO = 1'b0,  // expand the byte by the stand-alone rules
    TOK_RAW  = 1'b1   // emit the byte as is
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [7:0] val;
  } tok_t;

  // One accepted input item turned into up to three tokens
  typedef struct packed {
    tok_t [2:0] tok;
    logic [1:0] cnt;
  } job_t;

  function automatic logic [1:0] solo_len(logic [7:0] b);
    logic [1:0] len;
    if (b < BYTE_SPACE) begin
      len = (b == BYTE_TAB || b == BYTE_LF || b == BYTE_CR) ? 2'd1 : 2'd0;
    end else if (b < BYTE_DEL) begin
      len = 2'd1;
    end else if (b == BYTE_EURO) begin
      len = 2'd3;
    end else if (b == BYTE_NEL) begin
      len = 2'd2;
    end else if (b < BYTE_NBSP) begin
      len = 2'd0;
    end else if (b < BYTE_LEAD2LO) begin
      len = 2'd2;
    end else begin
      len = 2'd0;
    end
    return len;
  endfunction

  function automatic logic [7:0] solo_byte(logic [7:0] b, logic [1:0] sub);
    logic [7:0] v;
    v = b;
    if (b == BYTE_EURO) begin
      case (sub)
        2'd0:    v = EURO_B0;
        2'd1:    v = EURO_B1;
        default: v = EURO_B2;
      endcase
    end else if (b == BYTE_NEL) begin
      v = (sub == 2'd0) ? BYTE_LF : BYTE_CR;
    end else if (b >= BYTE_NBSP && b < 8'd192) begin
      v = (sub == 2'd0) ? BYTE_C2 : b;
    end else if (b >= 8'd192 && b < BYTE_LEAD2LO) begin
      v = (sub == 2'd0) ? BYTE_C3 : (b - LATIN_OFFSET);
    end
    return v;
  endfunction

  function automatic logic [1:0] tok_len(tok_t t);
    return (t.kind == TOK_RAW) ? 2'd1 : solo_len(t.val);
  endfunction

  function automatic logic [7:0] tok_byte(tok_t t, logic [1:0] sub);
    return (t.kind == TOK_RAW) ? t.val : solo_byte(t.val, sub);
  endfunction

endpackage

`default_nettype wire

// ----- hdl/utf8_byte_sanitizer.sv -----
// Top level of the UTF-8 byte sanitizer: front end, job queue and output expander.
//
// The block takes one raw byte per transfer and produces the cleaned UTF-8 bytes it
// causes, with run_end_o on the last of them. The input side accepts one byte per
// cycle as long as the two-entry job queue has room; a byte that produces nothing
// (held continuation bytes, dropped controls, lead bytes) never enters the queue.
// The output expander emits one byte per cycle while out_ready_i allows, so an item
// yielding 1 to 8 bytes holds it until its last byte; the sustained rate is one output
// byte per cycle absent back-pressure; the input stalls only when bursts fill the queue.
`default_nettype none

module utf8_byte_sanitizer (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       in_last_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            run_end_o
);

  logic           fq_valid, fq_ready;
  usan_pkg::job_t fq_job;
  logic           qb_valid, qb_ready;
  usan_pkg::job_t qb_job;

  usan_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .job_valid_o (fq_valid),
    .job_ready_i (fq_ready),
    .job_o       (fq_job)
  );

  usan_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_job_i   (fq_job),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_job_o    (qb_job)
  );

  usan_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (qb_valid),
    .job_ready_o (qb_ready),
    .job_i       (qb_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .run_end_o   (run_end_o)
  );

endmodule

`default_nettype wire

// ----- hdl/usan_front.sv -----
// Front end: accepts input bytes, tracks pending multi-byte sequences, builds token jobs.
`default_nettype none

module usan_front (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [7:0]      in_byte_i,
  input  wire logic            in_last_i,
  output logic                 job_valid_o,
  input  wire logic            job_ready_i,
  output usan_pkg::job_t       job_o
);

  logic [7:0] lead_q, lead_d;
  logic [1:0] need_q, need_d;
  logic [1:0] hcnt_q, hcnt_d;
  logic [7:0] held_q [2];
  logic       store;
  logic       accept;
  logic       cont;
  logic       is_lead;
  logic       has_out;
  usan_pkg::job_t job;

  assign cont    = (in_byte_i[7:6] == 2'b10);
  assign is_lead = (in_byte_i >= usan_pkg::BYTE_LEAD2LO) && (in_byte_i < usan_pkg::BYTE_BADLO);
  assign in_ready_o = job_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    lead_d = lead_q;
    need_d = need_q;
    hcnt_d = hcnt_q;
    store  = 1'b0;
    job    = '0;
    if (need_q != 2'd0 && cont && ({1'b0, hcnt_q} + 3'd1 >= {1'b0, need_q})) begin
      // sequence complete: only two-byte ones outside the C1 range survive
      if (need_q == 2'd1 &&
          !(lead_q == usan_pkg::BYTE_C2 && in_byte_i < usan_pkg::BYTE_NBSP)) begin
        job.tok[0] = '{kind: usan_pkg::TOK_RAW, val: lead_q};
        job.tok[1] = '{kind: usan_pkg::TOK_RAW, val: in_byte_i};
        job.cnt    = 2'd2;
      end
      lead_d = '0;
      need_d = '0;
      hcnt_d = '0;
    end else if (need_q != 2'd0 && cont && !in_last_i) begin
      store  = 1'b1;
      hcnt_d = hcnt_q + 2'd1;
    end else begin
      // drop the lead, replay held bytes, then the new byte on its own
      case (hcnt_q)
        2'd1: begin
          job.tok[0] = '{kind: usan_pkg::TOK_SOLO, val: held_q[0]};
          job.tok[1] = '{kind: usan_pkg::TOK_SOLO, val: in_byte_i};
          job.cnt    = 2'd2;
        end
        2'd2: begin
          job.tok[0] = '{kind: usan_pkg::TOK_SOLO, val: held_q[0]};
          job.tok[1] = '{kind: usan_pkg::TOK_SOLO, val: held_q[1]};
          job.tok[2] = '{kind: usan_pkg::TOK_SOLO, val: in_byte_i};
          job.cnt    = 2'd3;
        end
        default: begin
          job.tok[0] = '{kind: usan_pkg::TOK_SOLO, val: in_byte_i};
          job.cnt    = 2'd1;
        end
      endcase
      lead_d = '0;
      need_d = '0;
      hcnt_d = '0;
      if (is_lead && !in_last_i) begin
        lead_d = in_byte_i;
        if (in_byte_i < usan_pkg::BYTE_LEAD3LO) begin
          need_d = 2'd1;
        end else if (in_byte_i < usan_pkg::BYTE_LEAD4LO) begin
          need_d = 2'd2;
        end else begin
          need_d = 2'd3;
        end
      end
    end
  end

  // Skip jobs that expand to nothing
  always_comb begin
    has_out = 1'b0;
    if (job.cnt >= 2'd1 && usan_pkg::tok_len(job.tok[0]) != 2'd0) has_out = 1'b1;
    if (job.cnt >= 2'd2 && usan_pkg::tok_len(job.tok[1]) != 2'd0) has_out = 1'b1;
    if (job.cnt == 2'd3 && usan_pkg::tok_len(job.tok[2]) != 2'd0) has_out = 1'b1;
  end

  assign job_valid_o = in_valid_i && has_out;
  assign job_o       = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= '0;
      need_q <= '0;
      hcnt_q <= '0;
    end else if (accept) begin
      lead_q <= lead_d;
      need_q <= need_d;
      hcnt_q <= hcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && store) begin
      held_q[hcnt_q[0]] <= in_byte_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/usan_fifo.sv -----
// Two-entry job queue between the front end and the output expander.
`default_nettype none

module usan_fifo (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  wire usan_pkg::job_t  push_job_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i,
  output usan_pkg::job_t       pop_job_o
);

  usan_pkg::job_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q != 2'd3) else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == 2'd0 || count_q == 2'd2) |-> (wr_ptr_q == rd_ptr_q))
    else $error("queue pointers disagree with count");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (count_q == $past(count_q) + 2'd1))
    else $error("queue count missed a push");

endmodule

`default_nettype wire

// ----- hdl/usan_back.sv -----
// Back end: expands queued token jobs into output bytes, one per cycle while out_ready_i allows.
`default_nettype none

module usan_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            job_valid_i,
  output logic                 job_ready_o,
  input  wire usan_pkg::job_t  job_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [7:0]           out_byte_o,
  output logic                 run_end_o
);

  logic [1:0] idx_q, sub_q;
  logic       out_valid_q;
  logic [7:0] out_byte_q;
  logic       run_end_q;
  logic [1:0] len0, len1, len2, cur_len;
  logic [1:0] cur;
  logic       any_after;
  logic       last_in_tok;
  logic       last_byte;
  logic       emit;
  logic [7:0] byte_cur;

  assign len0 = (job_i.cnt >= 2'd1) ? usan_pkg::tok_len(job_i.tok[0]) : 2'd0;
  assign len1 = (job_i.cnt >= 2'd2) ? usan_pkg::tok_len(job_i.tok[1]) : 2'd0;
  assign len2 = (job_i.cnt == 2'd3) ? usan_pkg::tok_len(job_i.tok[2]) : 2'd0;

  // First token at or after idx_q that yields output
  always_comb begin
    if (idx_q == 2'd0 && len0 != 2'd0) begin
      cur = 2'd0;
    end else if (idx_q <= 2'd1 && len1 != 2'd0) begin
      cur = 2'd1;
    end else begin
      cur = 2'd2;
    end
  end

  always_comb begin
    case (cur)
      2'd0: begin
        cur_len   = len0;
        any_after = (len1 != 2'd0) || (len2 != 2'd0);
        byte_cur  = usan_pkg::tok_byte(job_i.tok[0], sub_q);
      end
      2'd1: begin
        cur_len   = len1;
        any_after = (len2 != 2'd0);
        byte_cur  = usan_pkg::tok_byte(job_i.tok[1], sub_q);
      end
      default: begin
        cur_len   = len2;
        any_after = 1'b0;
        byte_cur  = usan_pkg::tok_byte(job_i.tok[2], sub_q);
      end
    endcase
  end

  assign last_in_tok = (sub_q + 2'd1 == cur_len);
  assign last_byte   = last_in_tok && !any_after;
  assign emit        = job_valid_i && (!out_valid_q || out_ready_i);
  assign job_ready_o = emit && last_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      sub_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
        if (last_byte) begin
          idx_q <= '0;
          sub_q <= '0;
        end else if (last_in_tok) begin
          idx_q <= cur + 2'd1;
          sub_q <= '0;
        end else begin
          sub_q <= sub_q + 2'd1;
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= byte_cur;
      run_end_q  <= last_byte;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign run_end_o   = run_end_q;

endmodule

`default_nettype wire

// ----- tb/utf8_byte_sanitizer_checker.sv -----
// Checker for the UTF-8 byte sanitizer: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module utf8_byte_sanitizer_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic       run_end_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } clean_byte_t;

  clean_byte_t cleaned_q[$];  // bytes still owed by the block, oldest first
  clean_byte_t burst[$];      // bytes caused by the transfer being predicted
  clean_byte_t want;

  logic [7:0] seq_lead;
  logic [1:0] seq_need;
  logic [1:0] seq_got;
  logic [7:0] seq_held [2];

  int fails;
  int checked;

  assign fail_count_o = fails;
  assign checked_o    = checked;

  task automatic report(input string msg);
    $display("%0t: mismatch: %s", $realtime, msg);
    fails++;
  endtask

  function automatic void put(input logic [7:0] b);
    burst.push_back('{value: b, last: 1'b0});
  endfunction

  function automatic void drop_sequence();
    seq_need = 2'd0;
    seq_got  = 2'd0;
    seq_lead = 8'd0;
  endfunction

  // Stand-alone rules for one byte; a lead byte opens a sequence unless it ends the stream
  function automatic void expand_alone(input logic [7:0] b, input logic last);
    if (b < usan_pkg::BYTE_SPACE) begin
      if (b == usan_pkg::BYTE_TAB || b == usan_pkg::BYTE_LF || b == usan_pkg::BYTE_CR) put(b);
    end else if (b < usan_pkg::BYTE_DEL) begin
      put(b);
    end else if (b < usan_pkg::BYTE_NBSP) begin
      if (b == usan_pkg::BYTE_EURO) begin
        put(usan_pkg::EURO_B0);
        put(usan_pkg::EURO_B1);
        put(usan_pkg::EURO_B2);
      end else if (b == usan_pkg::BYTE_NEL) begin
        put(usan_pkg::BYTE_LF);
        put(usan_pkg::BYTE_CR);
      end
    end else if (b < 8'd192) begin
      put(usan_pkg::BYTE_C2);
      put(b);
    end else if (b < usan_pkg::BYTE_LEAD2LO) begin
      put(usan_pkg::BYTE_C3);
      put(b - usan_pkg::LATIN_OFFSET);
    end else if (b < usan_pkg::BYTE_BADLO) begin
      if (!last) begin
        seq_lead = b;
        seq_need = (b < usan_pkg::BYTE_LEAD3LO) ? 2'd1 :
                   ((b < usan_pkg::BYTE_LEAD4LO) ? 2'd2 : 2'd3);
        seq_got  = 2'd0;
      end
    end
  endfunction

  // Drop the lead and replay the collected continuation bytes on their own
  function automatic void replay_held();
    int         cnt;
    logic [7:0] copy [2];
    cnt     = seq_got;
    copy[0] = seq_held[0];
    copy[1] = seq_held[1];
    drop_sequence();
    for (int k = 0; k < cnt && k < 2; k++) expand_alone(copy[k], 1'b0);
  endfunction

  function automatic void sanitize_byte(input logic [7:0] b, input logic last);
    logic        cont;
    clean_byte_t tail;
    burst.delete();
    cont = (b >= 8'd128 && b <= 8'd191);
    if (seq_need != 2'd0) begin
      if (cont) begin
        if (int'(seq_got) + 1 >= int'(seq_need)) begin
          if (seq_need == 2'd1 && !(seq_lead == usan_pkg::BYTE_C2 && b < usan_pkg::BYTE_NBSP)) begin
            put(seq_lead);
            put(b);
          end
          drop_sequence();
        end else if (last) begin
          replay_held();
          expand_alone(b, 1'b1);
        end else begin
          seq_held[seq_got[0]] = b;
          seq_got = seq_got + 2'd1;
        end
      end else begin
        replay_held();
        expand_alone(b, last);
      end
    end else begin
      expand_alone(b, last);
    end
    if (burst.size() > 0) begin
      tail = burst[burst.size() - 1];
      tail.last = 1'b1;
      burst[burst.size() - 1] = tail;
    end
    foreach (burst[i]) cleaned_q.push_back(burst[i]);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drop_sequence();
      seq_held[0] = 8'd0;
      seq_held[1] = 8'd0;
      cleaned_q.delete();
      fails     = 0;
      checked   = 0;
      pending_o <= 0;
    end else begin
      // predict first so a same-cycle result would still find its expectation
      if (in_valid_i && in_ready_i) sanitize_byte(in_byte_i, in_last_i);
      if (out_valid_i && out_ready_i) begin
        checked++;
        if (cleaned_q.size() == 0) begin
          report($sformatf("unexpected byte %02h run_end %0b", out_byte_i, run_end_i));
        end else begin
          want = cleaned_q.pop_front();
          if (out_byte_i !== want.value)
            report($sformatf("byte %02h, predicted %02h", out_byte_i, want.value));
          if (run_end_i !== want.last)
            report($sformatf("run_end %0b on byte %02h, predicted %0b",
                             run_end_i, out_byte_i, want.last));
        end
      end
      pending_o <= cleaned_q.size();
    end
  end

endmodule

// ----- tb/tb_utf8_byte_sanitizer.sv -----
// Testbench top for the UTF-8 byte sanitizer: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_utf8_byte_sanitizer;

  localparam int STALL_LIMIT  = 4000;
  localparam int SETTLE_TICKS = 32;
  localparam int PHASE_ITEMS  = 107;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte   = 8'd0;
  logic       in_last   = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       run_end;

  int fail_count;
  int pending;
  int checked;
  int items_sent   = 0;
  int snd_idle_pct = 22;
  int rcv_idle_pct = 79;
  int quiet_cycles;

  // bit 8 carries the end-of-stream flag
  logic [8:0] directed [] = '{
    9'h000, 9'h009, 9'h00D, 9'h020, 9'h07F, 9'h080, 9'h085, 9'h096, 9'h0A0, 9'h0BF,
    9'h0C0, 9'h0C1, 9'h0F5, 9'h0FF,
    9'h0C2, 9'h0A0,                 // kept two-byte sequence
    9'h0C2, 9'h085,                 // C1 control in two-byte form
    9'h0DF, 9'h0BF,
    9'h0E2, 9'h082, 9'h0AC,         // three-byte sequence, removed
    9'h0F4, 9'h080, 9'h080, 9'h041, // broken four-byte, held bytes replayed
    9'h0E2, 9'h180,                 // cut short by end of stream
    9'h1C3                          // lead byte that ends the stream
  };

  utf8_byte_sanitizer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_byte_i   (in_byte),
    .in_last_i   (in_last),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_byte_o  (out_byte),
    .run_end_o   (run_end)
  );

  utf8_byte_sanitizer_checker u_checker (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_byte_i    (in_byte),
    .in_last_i    (in_last),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_byte_i   (out_byte),
    .run_end_i    (run_end),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= rcv_idle_pct);

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    @(posedge rst_n);
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("stalled for %0d cycles with %0d bytes outstanding", quiet_cycles, pending);
    $display("[utf8_byte_sanitizer] ERROR");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  // Hold the sender until every predicted byte has come out, then let the block settle
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(191, 128));
  endfunction

  function automatic logic [7:0] non_cont_byte();
    return ($urandom_range(1) == 0) ? 8'($urandom_range(127, 0)) : 8'($urandom_range(255, 192));
  endfunction

  function automatic int needed_for(input logic [7:0] lead);
    return (lead < usan_pkg::BYTE_LEAD3LO) ? 1 : ((lead < usan_pkg::BYTE_LEAD4LO) ? 2 : 3);
  endfunction

  // Well-formed sequences with random content, noise, broken runs and runs cut short by end of stream
  task automatic send_random_run();
    int         kind;
    int         need;
    int         k;
    logic [7:0] lead;
    kind = $urandom_range(99);
    if (kind < 15) begin
      send_byte(8'($urandom_range(127, 0)), ($urandom_range(19) == 0));
    end else if (kind < 27) begin
      send_byte(8'($urandom_range(255, 0)), ($urandom_range(19) == 0));
    end else if (kind < 72) begin
      if (kind < 45) lead = 8'($urandom_range(223, 194));
      else if (kind < 60) lead = 8'($urandom_range(239, 224));
      else lead = 8'($urandom_range(244, 240));
      need = needed_for(lead);
      send_byte(lead, 1'b0);
      for (int i = 0; i < need; i++) send_byte(cont_byte(), ($urandom_range(19) == 0));
    end else if (kind < 86) begin
      lead = 8'($urandom_range(244, 194));
      k = $urandom_range(needed_for(lead) - 1, 0);
      send_byte(lead, 1'b0);
      for (int i = 0; i < k; i++) send_byte(cont_byte(), 1'b0);
      send_byte(non_cont_byte(), ($urandom_range(7) == 0));
    end else begin
      lead = 8'($urandom_range(244, 194));
      k = $urandom_range(needed_for(lead) - 1, 0);
      send_byte(lead, (k == 0));
      for (int i = 0; i < k; i++) send_byte(cont_byte(), (i == k - 1));
    end
  endtask

  task automatic run_phase(input int snd_pct, input int rcv_pct);
    int goal;
    snd_idle_pct = snd_pct;
    rcv_idle_pct = rcv_pct;
    goal = items_sent + PHASE_ITEMS;
    while (items_sent < goal) send_random_run();
    hold_until_drained();
  endtask

  initial begin
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);
    hold_until_drained();

    run_phase(22, 79);
    run_phase(79, 22);
    run_phase(0, 0);

    $display("sent %0d input bytes (controls, Latin-1, 2/3/4-byte, broken and cut-short runs)",
             items_sent);
    $display("compared %0d output bytes under three sender/receiver idle mixes", checked);
    if (fail_count == 0 && pending == 0) begin
      $display("[utf8_byte_sanitizer] OK");
    end else begin
      $display("[utf8_byte_sanitizer] ERROR");
    end
    $finish;
  end

endmodule
